// File: design/tga_pkg.sv
package tga_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_LAST      = 5'd17;

  localparam logic [7:0] IMG_TRUECOLOR = 8'd2;
  localparam logic [7:0] BPP_15 = 8'd15;
  localparam logic [7:0] BPP_16 = 8'd16;
  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;

  localparam logic [2:0] ST_PIXEL = 3'd0;
  localparam logic [2:0] ST_CMAP  = 3'd1;
  localparam logic [2:0] ST_KIND  = 3'd2;
  localparam logic [2:0] ST_DEPTH = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef enum logic [1:0] {
    FMT_15,
    FMT_16,
    FMT_24,
    FMT_32
  } fmt_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    logic [2:0]  status;
    fmt_t        fmt;
    logic [23:0] held;
    logic [7:0]  final_byte;
    logic        eor;
    logic        last;
  } op_t;

endpackage

// File: design/tga_chan_if.sv
interface tga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface tga_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [2:0] status;
  logic       end_of_row;
  logic       last_result;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output status, output end_of_row, output last_result, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input status, input end_of_row, input last_result, output ready);
endinterface

// File: design/tga_front.sv
module tga_front (
  input  logic          clk,
  input  logic          rst_n,
  tga_in_if.sink        in_chan,
  input  logic          q_full,
  output logic          push,
  output tga_pkg::op_t  push_op
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [4:0]   hpos_r, hpos_nxt;
  logic [7:0]   id_left_r, id_left_nxt;
  logic [7:0]   cmap_r, cmap_nxt;
  logic [7:0]   kind_r, kind_nxt;
  logic [15:0]  width_r, width_nxt;
  logic [15:0]  height_r, height_nxt;
  logic [7:0]   bpp_r, bpp_nxt;
  logic [15:0]  col_r, col_nxt;
  logic [15:0]  row_r, row_nxt;
  logic [1:0]   bip_r, bip_nxt;
  logic [23:0]  held_r, held_nxt;

  logic          accept;
  logic          in_hdr;
  logic [4:0]    pos;
  logic [7:0]    b;
  tga_pkg::fmt_t fmt;
  logic [1:0]    bip_final;
  logic [2:0]    st;
  logic          eor;
  logic          last;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && in_chan.ready;
  assign b      = in_chan.data_byte;
  assign in_hdr = in_chan.file_start || (phase_r == PH_HEADER);
  assign pos    = in_chan.file_start ? tga_pkg::HDR_ID_LEN : hpos_r;

  always_comb begin
    case (bpp_r)
      tga_pkg::BPP_15: fmt = tga_pkg::FMT_15;
      tga_pkg::BPP_16: fmt = tga_pkg::FMT_16;
      tga_pkg::BPP_24: fmt = tga_pkg::FMT_24;
      default:         fmt = tga_pkg::FMT_32;
    endcase
    case (fmt)
      tga_pkg::FMT_15, tga_pkg::FMT_16: bip_final = 2'd1;
      tga_pkg::FMT_24:                  bip_final = 2'd2;
      default:                          bip_final = 2'd3;
    endcase
  end

  // header check, tested in priority order
  always_comb begin
    if (cmap_r != 8'd0) begin
      st = tga_pkg::ST_CMAP;
    end else if (kind_r != tga_pkg::IMG_TRUECOLOR) begin
      st = tga_pkg::ST_KIND;
    end else if (bpp_r != tga_pkg::BPP_15 && bpp_r != tga_pkg::BPP_16 &&
                 bpp_r != tga_pkg::BPP_24 && bpp_r != tga_pkg::BPP_32) begin
      st = tga_pkg::ST_DEPTH;
    end else if (width_r == 16'd0 || height_r == 16'd0) begin
      st = tga_pkg::ST_EMPTY;
    end else begin
      st = tga_pkg::ST_PIXEL;
    end
  end

  assign eor  = ({1'b0, col_r} + 17'd1) >= {1'b0, width_r};
  assign last = eor && (({1'b0, row_r} + 17'd1) >= {1'b0, height_r});

  always_comb begin
    phase_nxt   = phase_r;
    hpos_nxt    = hpos_r;
    id_left_nxt = id_left_r;
    cmap_nxt    = cmap_r;
    kind_nxt    = kind_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    bpp_nxt     = bpp_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    bip_nxt     = bip_r;
    held_nxt    = held_r;
    push        = 1'b0;
    push_op.status     = st;
    push_op.fmt        = fmt;
    push_op.held       = held_r;
    push_op.final_byte = b;
    push_op.eor        = eor;
    push_op.last       = last;

    if (accept && in_hdr) begin
      case (pos)
        tga_pkg::HDR_ID_LEN:    id_left_nxt = b;
        tga_pkg::HDR_CMAP_TYPE: cmap_nxt = b;
        tga_pkg::HDR_IMG_TYPE:  kind_nxt = b;
        tga_pkg::HDR_WIDTH_LO:  width_nxt = {width_r[15:8], b};
        tga_pkg::HDR_WIDTH_HI:  width_nxt = {b, width_r[7:0]};
        tga_pkg::HDR_HEIGHT_LO: height_nxt = {height_r[15:8], b};
        tga_pkg::HDR_HEIGHT_HI: height_nxt = {b, height_r[7:0]};
        tga_pkg::HDR_DEPTH:     bpp_nxt = b;
        default: ;
      endcase
      if (pos != tga_pkg::HDR_LAST) begin
        hpos_nxt  = pos + 5'd1;
        phase_nxt = PH_HEADER;
      end else begin
        hpos_nxt = 5'd0;
        if (st != tga_pkg::ST_PIXEL) begin
          phase_nxt = PH_IDLE;
          push      = 1'b1;
          push_op.eor  = 1'b0;
          push_op.last = 1'b1;
        end else begin
          col_nxt   = 16'd0;
          row_nxt   = 16'd0;
          bip_nxt   = 2'd0;
          held_nxt  = 24'd0;
          phase_nxt = (id_left_r != 8'd0) ? PH_SKIP : PH_PIXEL;
        end
      end
    end else if (accept && phase_r == PH_SKIP) begin
      id_left_nxt = id_left_r - 8'd1;
      if (id_left_nxt == 8'd0) begin
        phase_nxt = PH_PIXEL;
      end
    end else if (accept && phase_r == PH_PIXEL) begin
      if (bip_r != bip_final) begin
        case (bip_r)
          2'd0:    held_nxt[7:0]   = b;
          2'd1:    held_nxt[15:8]  = b;
          default: held_nxt[23:16] = b;
        endcase
        bip_nxt = bip_r + 2'd1;
      end else begin
        push     = 1'b1;
        bip_nxt  = 2'd0;
        held_nxt = 24'd0;
        if (eor) begin
          col_nxt = 16'd0;
          row_nxt = row_r + 16'd1;
        end else begin
          col_nxt = col_r + 16'd1;
        end
        if (last) begin
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hpos_r    <= 5'd0;
      id_left_r <= 8'd0;
      cmap_r    <= 8'd0;
      kind_r    <= 8'd0;
      width_r   <= 16'd0;
      height_r  <= 16'd0;
      bpp_r     <= 8'd0;
      col_r     <= 16'd0;
      row_r     <= 16'd0;
      bip_r     <= 2'd0;
      held_r    <= 24'd0;
    end else begin
      phase_r   <= phase_nxt;
      hpos_r    <= hpos_nxt;
      id_left_r <= id_left_nxt;
      cmap_r    <= cmap_nxt;
      kind_r    <= kind_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      bpp_r     <= bpp_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      bip_r     <= bip_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

// File: design/tga_fifo.sv
module tga_fifo #(
  parameter int unsigned DEPTH = tga_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tga_pkg::op_t  push_op,
  input  logic          pop,
  output tga_pkg::op_t  head_op,
  output logic          full,
  output logic          empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  tga_pkg::op_t  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/tga_back.sv
module tga_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tga_pkg::op_t  head_op,
  input  logic          q_empty,
  output logic          pop,
  tga_out_if.source     out_chan
);

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  red_r, green_r, blue_r, alpha_r;
  logic [2:0]  status_r;
  logic        eor_r, last_r;
  logic [7:0]  red_nxt, green_nxt, blue_nxt, alpha_nxt;
  logic [15:0] word16;

  assign pop    = !q_empty && (!out_valid_r || out_chan.ready);
  assign word16 = {head_op.final_byte, head_op.held[7:0]};

  always_comb begin
    case (head_op.fmt)
      tga_pkg::FMT_15, tga_pkg::FMT_16: begin
        red_nxt   = {3'b000, word16[14:10]};
        green_nxt = {3'b000, word16[9:5]};
        blue_nxt  = {3'b000, word16[4:0]};
        alpha_nxt = (head_op.fmt == tga_pkg::FMT_16) ? {8{word16[15]}} : 8'hFF;
      end
      tga_pkg::FMT_24: begin
        red_nxt   = head_op.held[7:0];
        green_nxt = head_op.held[15:8];
        blue_nxt  = head_op.final_byte;
        alpha_nxt = 8'hFF;
      end
      default: begin
        red_nxt   = head_op.held[7:0];
        green_nxt = head_op.held[15:8];
        blue_nxt  = head_op.held[23:16];
        alpha_nxt = head_op.final_byte;
      end
    endcase
    // status results carry no pixel
    if (head_op.status != tga_pkg::ST_PIXEL) begin
      red_nxt   = 8'd0;
      green_nxt = 8'd0;
      blue_nxt  = 8'd0;
      alpha_nxt = 8'd0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
      alpha_r  <= alpha_nxt;
      status_r <= head_op.status;
      eor_r    <= head_op.eor;
      last_r   <= head_op.last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.red         = red_r;
  assign out_chan.green       = green_r;
  assign out_chan.blue        = blue_r;
  assign out_chan.alpha       = alpha_r;
  assign out_chan.status      = status_r;
  assign out_chan.end_of_row  = eor_r;
  assign out_chan.last_result = last_r;

endmodule

// File: design/tga_truecolor_to_rgba_stream.sv
// uncompressed true-colour tga decoder, byte stream in, rgba pixels out
// in_chan: one file byte per transaction, file_start marks the first byte of a
//   file and always restarts header parsing, whatever was in progress
// out_chan: one transaction per pixel (status 0) or one status transaction
//   when the header is rejected (colour map, image type, depth, empty image)
// the 18-byte header and image id bytes give no output; a pixel is emitted on
//   its last byte (2, 3 or 4 bytes); bytes after the last pixel or an error
//   are dropped until the next file_start
// a pixel's last byte is written into the result queue, and from there into the
//   output register that drives out_chan.valid
// throughput: one byte per cycle, sustained while out_chan.ready is high; the
//   front parser takes a byte every cycle while the result queue has room, and
//   the output register drains one result a cycle while out_chan.ready is high
// reset: synchronous, active low; parser returns to idle, queue and output
//   register empty
// receiver stall: the output register holds, the queue fills, then
//   in_chan.ready drops until the receiver takes a result
module tga_truecolor_to_rgba_stream #(
  parameter int unsigned QUEUE_DEPTH = tga_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  tga_in_if.sink     in_chan,
  tga_out_if.source  out_chan
);

  logic         push, pop, q_full, q_empty;
  tga_pkg::op_t push_op, head_op;

  tga_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  tga_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  tga_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_op  (head_op),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_chan (out_chan)
  );

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("result queue overflow");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("result queue underflow");

  a_status_final : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != tga_pkg::ST_PIXEL) |->
      (out_chan.last_result && !out_chan.end_of_row && out_chan.red == 8'd0 &&
       out_chan.green == 8'd0 && out_chan.blue == 8'd0 && out_chan.alpha == 8'd0))
    else $error("status result not a clean final transaction");

endmodule
